// ===== sv/fpa_pkg.sv =====
// ----------------------------------------------------------------------------
// fpa_pkg
// Shared types, codes and helpers of the fixed-point ALU pipeline.
// ----------------------------------------------------------------------------
package fpa_pkg;

  localparam int DataW           = 32;
  localparam int FracBitsDefault = 8;
  localparam int ProdW           = 64;
  localparam int DenW            = DataW + 1;
  localparam int RemW            = 66;

  typedef enum logic [3:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_DIV,
    OP_LT, OP_GT, OP_LE, OP_GE, OP_EQ, OP_NE,
    OP_MIN, OP_MAX, OP_INC, OP_DEC, OP_TOINT, OP_FROMINT
  } op_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_OVF  = 2'd1,
    ST_DIVZ = 2'd2
  } status_t;

  localparam logic [DataW-1:0] S32Max = {1'b0, {(DataW-1){1'b1}}};
  localparam logic [DataW-1:0] S32Min = {1'b1, {(DataW-1){1'b0}}};

  // request as it moves down the pipeline
  typedef struct packed {
    op_t              op;
    logic [DataW-1:0] res;
    logic             cmp;
    status_t          st;
    logic [ProdW-1:0] prod;
    logic [RemW-1:0]  rem;
    logic [DenW-1:0]  den;
    logic [DataW-1:0] quo;
    logic             neg;
    logic             dovf;
  } fpa_word_t;

  // saturate a 33-bit signed sum to 32 bits
  function automatic logic [DataW-1:0] sat33(logic [DataW:0] s);
    logic [DataW-1:0] v;
    if (s[DataW] != s[DataW-1]) begin
      v = s[DataW] ? S32Min : S32Max;
    end else begin
      v = s[DataW-1:0];
    end
    return v;
  endfunction

  function automatic logic ovf33(logic [DataW:0] s);
    return s[DataW] ^ s[DataW-1];
  endfunction

endpackage

// ===== sv/fpa_in_if.sv =====
// ----------------------------------------------------------------------------
// fpa_in_if
// Operation request channel: valid/ready with opcode and two operands.
// ----------------------------------------------------------------------------
interface fpa_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  op;
  logic signed [31:0] operand_a;
  logic signed [31:0] operand_b;

  modport source (output valid, op, operand_a, operand_b, input ready);
  modport sink   (input valid, op, operand_a, operand_b, output ready);
endinterface

// ===== sv/fpa_out_if.sv =====
// ----------------------------------------------------------------------------
// fpa_out_if
// Result channel: valid/ready with value, compare flag and status.
// ----------------------------------------------------------------------------
interface fpa_out_if;
  logic        valid;
  logic        ready;
  logic signed [31:0] result_value;
  logic        compare_true;
  logic [1:0]  status;

  modport source (output valid, result_value, compare_true, status, input ready);
  modport sink   (input valid, result_value, compare_true, status, output ready);
endinterface

// ===== sv/fixed_point_alu_unit.sv =====
// ----------------------------------------------------------------------------
// fixed_point_alu_unit
// Pipelined signed fixed-point ALU with saturation and rounding.
// ----------------------------------------------------------------------------
// Usage:
//   Send a request on in_req (op, operand_a, operand_b, raw fixed-point with
//   FRAC_BITS fraction bits); it is taken at a clock edge where valid and
//   ready are both high. One result per request comes back on out_res, in
//   request order, taken when out_res.valid and out_res.ready are both high.
//   Every opcode passes the same stages: one entry stage (simple ops,
//   32x32 multiplier, divider setup), 32 division stages resolving one
//   quotient bit each, and one exit stage (rounding, saturation, output
//   register). Throughput is one request per cycle while out_res.ready
//   holds; the 32-stage divider chain sets the depth, not the rate.
//   Each stage holds its request while the next stage is full and stalled,
//   and fills any bubble, so a stalled receiver backs the pipeline up
//   without dropping or repeating anything; in_req.ready falls only once
//   every stage is occupied.
//   Reset (rst_n low, synchronous) empties all stages; data registers are not reset.
// ----------------------------------------------------------------------------
module fixed_point_alu_unit #(
  parameter int FRAC_BITS = fpa_pkg::FracBitsDefault
) (
  input  logic      clk,
  input  logic      rst_n,
  fpa_in_if.sink    in_req,
  fpa_out_if.source out_res
);
  import fpa_pkg::*;

  localparam int Steps = DataW;

  logic      v   [Steps+1];
  fpa_word_t w   [Steps+1];
  logic      rdy [Steps+1];

  // entry stage
  fpa_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_req   (in_req),
    .out_valid(v[0]),
    .out_word (w[0]),
    .dn_ready (rdy[0])
  );

  // divider chain, most significant quotient bit first
  for (genvar i = 0; i < Steps; i++) begin : g_step
    fpa_div_step #(.BIT(Steps - 1 - i)) u_step (
      .clk      (clk),
      .rst_n    (rst_n),
      .in_valid (v[i]),
      .in_word  (w[i]),
      .up_ready (rdy[i]),
      .out_valid(v[i+1]),
      .out_word (w[i+1]),
      .dn_ready (rdy[i+1])
    );
  end

  // exit stage: round, saturate, hold for the receiver
  fpa_back #(.FRAC_BITS(FRAC_BITS)) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(v[Steps]),
    .in_word (w[Steps]),
    .up_ready(rdy[Steps]),
    .out_res (out_res)
  );

  // comparisons never carry a value
  a_cmp_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.compare_true |-> out_res.result_value == '0)
    else $error("compare result carries nonzero value");

  // division by zero reports zero
  a_divz_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_res.valid && out_res.status == ST_DIVZ |-> out_res.result_value == '0)
    else $error("division by zero with nonzero value");

  // an accepted request lands in the entry stage
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_req.valid && in_req.ready |=> v[0])
    else $error("accepted request lost at entry");

  // the last divider stage keeps its request while the exit stage stalls
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    v[Steps] && !rdy[Steps] |=> v[Steps])
    else $error("last divider stage dropped a request");

endmodule

// ===== sv/fpa_front.sv =====
// ----------------------------------------------------------------------------
// fpa_front
// Entry stage: simple operations, multiplier, divider setup.
// ----------------------------------------------------------------------------
module fpa_front #(
  parameter int FRAC_BITS = fpa_pkg::FracBitsDefault
) (
  input  logic              clk,
  input  logic              rst_n,
  fpa_in_if.sink            in_req,
  output logic              out_valid,
  output fpa_pkg::fpa_word_t out_word,
  input  logic              dn_ready
);
  import fpa_pkg::*;

  logic             valid_r;
  fpa_word_t        word_r, word_nxt;
  logic             up_ready;
  logic [DataW-1:0] a, b;
  logic [DataW:0]   a_x, b_x, sum, dif, incv, decv, mag_a, mag_b;
  logic signed [ProdW-1:0] a_w, fi, prod_w;
  logic             lt, eq;
  op_t              op;
  logic [RemW-1:0]  num;

  assign up_ready     = !valid_r || dn_ready;
  assign in_req.ready = up_ready;
  assign out_valid    = valid_r;
  assign out_word     = word_r;

  assign a    = in_req.operand_a;
  assign b    = in_req.operand_b;
  assign op   = op_t'(in_req.op);
  assign a_x  = {a[DataW-1], a};
  assign b_x  = {b[DataW-1], b};
  assign sum  = a_x + b_x;
  assign dif  = a_x - b_x;
  assign incv = a_x + (DataW+1)'(1);
  assign decv = a_x - (DataW+1)'(1);
  assign mag_a = a[DataW-1] ? ((DataW+1)'(0) - a_x) : a_x;
  assign mag_b = b[DataW-1] ? ((DataW+1)'(0) - b_x) : b_x;
  assign lt   = $signed(a) < $signed(b);
  assign eq   = a == b;
  assign a_w  = ProdW'($signed(a));
  assign fi   = a_w <<< FRAC_BITS;
  // full signed product, operands sign-extended by the 64-bit target
  assign prod_w = $signed(a) * $signed(b);
  assign num  = (RemW'(mag_a) << (FRAC_BITS + 1)) + RemW'(mag_b);

  always_comb begin
    word_nxt      = '0;
    word_nxt.op   = op;
    word_nxt.st   = ST_OK;
    word_nxt.prod = prod_w;
    word_nxt.rem  = num;
    word_nxt.den  = {mag_b[DataW-1:0], 1'b0};
    word_nxt.neg  = a[DataW-1] ^ b[DataW-1];
    word_nxt.dovf = num >= {1'b0, mag_b[DataW-1:0], 1'b0, {DataW{1'b0}}};
    case (op)
      OP_ADD: begin
        word_nxt.res = sat33(sum);
        if (ovf33(sum)) word_nxt.st = ST_OVF;
      end
      OP_SUB: begin
        word_nxt.res = sat33(dif);
        if (ovf33(dif)) word_nxt.st = ST_OVF;
      end
      OP_INC: begin
        word_nxt.res = sat33(incv);
        if (ovf33(incv)) word_nxt.st = ST_OVF;
      end
      OP_DEC: begin
        word_nxt.res = sat33(decv);
        if (ovf33(decv)) word_nxt.st = ST_OVF;
      end
      OP_DIV: begin
        if (b == '0) word_nxt.st = ST_DIVZ;
      end
      OP_LT:  word_nxt.cmp = lt;
      OP_GT:  word_nxt.cmp = !lt && !eq;
      OP_LE:  word_nxt.cmp = lt || eq;
      OP_GE:  word_nxt.cmp = !lt;
      OP_EQ:  word_nxt.cmp = eq;
      OP_NE:  word_nxt.cmp = !eq;
      OP_MIN: word_nxt.res = lt ? a : b;
      OP_MAX: word_nxt.res = (!lt && !eq) ? a : b;
      OP_TOINT: word_nxt.res = DataW'($signed(a) >>> FRAC_BITS);
      OP_FROMINT: begin
        if (fi[ProdW-1:DataW-1] != {(ProdW-DataW+1){fi[ProdW-1]}}) begin
          word_nxt.res = fi[ProdW-1] ? S32Min : S32Max;
          word_nxt.st  = ST_OVF;
        end else begin
          word_nxt.res = fi[DataW-1:0];
        end
      end
      default: word_nxt.res = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= in_req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      word_r <= word_nxt;
    end
  end

endmodule

// ===== sv/fpa_div_step.sv =====
// ----------------------------------------------------------------------------
// fpa_div_step
// One restoring division stage: resolve one quotient bit.
// ----------------------------------------------------------------------------
module fpa_div_step #(
  parameter int BIT = 0
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  fpa_pkg::fpa_word_t in_word,
  output logic               up_ready,
  output logic               out_valid,
  output fpa_pkg::fpa_word_t out_word,
  input  logic               dn_ready
);
  import fpa_pkg::*;

  logic            valid_r;
  fpa_word_t       word_r, word_nxt;
  logic [RemW-1:0] dsh;

  assign up_ready  = !valid_r || dn_ready;
  assign out_valid = valid_r;
  assign out_word  = word_r;
  assign dsh       = RemW'(in_word.den) << BIT;

  always_comb begin
    word_nxt = in_word;
    if (in_word.rem >= dsh) begin
      word_nxt.rem      = in_word.rem - dsh;
      word_nxt.quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      word_r <= word_nxt;
    end
  end

endmodule

// ===== sv/fpa_back.sv =====
// ----------------------------------------------------------------------------
// fpa_back
// Exit stage: round and saturate multiply, saturate divide, hold the result.
// ----------------------------------------------------------------------------
module fpa_back #(
  parameter int FRAC_BITS = fpa_pkg::FracBitsDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  fpa_pkg::fpa_word_t in_word,
  output logic               up_ready,
  fpa_out_if.source          out_res
);
  import fpa_pkg::*;

  localparam logic [ProdW-1:0] Half =
    (FRAC_BITS > 0) ? (ProdW'(1) << (FRAC_BITS - 1)) : '0;

  logic             valid_r;
  logic [DataW-1:0] res_r, res_nxt;
  logic             cmp_r;
  status_t          st_r, st_nxt;
  logic             mneg;
  logic [ProdW-1:0] mmag, q, lim;
  logic             sneg, big;

  assign up_ready             = !valid_r || out_res.ready;
  assign out_res.valid        = valid_r;
  assign out_res.result_value = res_r;
  assign out_res.compare_true = cmp_r;
  assign out_res.status       = st_r;

  assign mneg = in_word.prod[ProdW-1];
  assign mmag = mneg ? (ProdW'(0) - in_word.prod) : in_word.prod;

  always_comb begin
    res_nxt = in_word.res;
    st_nxt  = in_word.st;
    sneg    = 1'b0;
    q       = '0;
    big     = 1'b0;
    lim     = '0;
    if (in_word.op == OP_MUL || (in_word.op == OP_DIV && in_word.st == ST_OK)) begin
      if (in_word.op == OP_MUL) begin
        sneg = mneg;
        q    = (mmag + Half) >> FRAC_BITS;
      end else begin
        sneg = in_word.neg;
        q    = ProdW'(in_word.quo);
        big  = in_word.dovf;
      end
      lim = sneg ? ProdW'(S32Min) : ProdW'(S32Max);
      if (big || q > lim) begin
        res_nxt = sneg ? S32Min : S32Max;
        st_nxt  = ST_OVF;
      end else begin
        res_nxt = sneg ? (DataW'(0) - q[DataW-1:0]) : q[DataW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      res_r <= res_nxt;
      cmp_r <= in_word.cmp;
      st_r  <= st_nxt;
    end
  end

endmodule
